[src/ssa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and codes for the sequence statistics accumulator.
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam logic [1:0] OP_SYMBOL = 2'd0;
    localparam logic [1:0] OP_END    = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [2:0] TBL_BASE   = 3'd0;
    localparam logic [2:0] TBL_QUAL   = 3'd1;
    localparam logic [2:0] TBL_BCOUNT = 3'd2;
    localparam logic [2:0] TBL_BSUM   = 3'd3;
    localparam logic [2:0] TBL_SCALAR = 3'd4;

    localparam logic [11:0] SC_COUNT = 12'd0;
    localparam logic [11:0] SC_TOTAL = 12'd1;
    localparam logic [11:0] SC_MIN   = 12'd2;
    localparam logic [11:0] SC_MAX   = 12'd3;

    localparam logic [1:0] CFG_COUNT_BASES     = 2'd0;
    localparam logic [1:0] CFG_COUNT_QUALITIES = 2'd1;
    localparam logic [1:0] CFG_BIN_LENGTHS     = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  base;
        logic [7:0]  qual;
        logic        has_q;
        logic [2:0]  table_sel;
        logic [11:0] index;
    } t_item;

endpackage

[src/ssa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[src/ssa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_front
// Input stage and two-entry queue towards the execution engine.
// ----------------------------------------------------------------------------
module ssa_front
    import ssa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_full,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);
    t_item       r_q [2];
    logic [1:0]  r_cnt;
    logic        r_rd;
    logic        w_push;
    logic        w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign w_push  = i_push && !o_full && (i_item.op != OP_NOP);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];
    assign w_pop   = o_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
        if (w_push) begin
            r_q[r_rd ^ r_cnt[0]] <= i_item;
        end
    end
endmodule

[src/ssa_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_back
// Execution engine: histogram updates, length statistics, binning and reads.
// ----------------------------------------------------------------------------
module ssa_back
    import ssa_pkg::*;
#(
    parameter int LEN_BINS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2:0]  i_cfg,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_take,
    output logic        o_res_valid,
    output logic [63:0] o_res,
    input  logic        i_res_take
);
    localparam int BW = $clog2(LEN_BINS);
    localparam int CW = (BW > 8) ? BW : 8;
    localparam logic [2:0] S_IDLE = 3'd0, S_CLR = 3'd1, S_RD = 3'd2, S_WR = 3'd3,
                           S_SQRT = 3'd4, S_OUT = 3'd5;

    logic [2:0]    r_st;
    t_item         r_it;
    logic [CW-1:0] r_clr;
    logic [31:0]   r_cur, r_len, r_min, r_max;
    logic [63:0]   r_total, r_seqs;
    logic [63:0]   r_res;
    logic          r_resv;
    logic [41:0]   r_v, r_root, r_bit;
    logic          r_bin_on;
    logic [BW-1:0] r_bin;

    logic [63:0]   w_bh, w_qh, w_bs;
    logic [31:0]   w_bc;
    logic          w_clr;
    logic [BW-1:0] w_baddr;
    logic [41:0]   w_rb;

    assign w_clr   = (r_st == S_CLR);
    assign w_baddr = (r_st == S_IDLE) ? BW'(i_item.index) : r_bin;

    ssa_ram #(.WIDTH(64), .DEPTH(256)) u_bh (
        .i_clk(i_clk),
        .i_we(w_clr || (r_st == S_WR && r_it.op == OP_SYMBOL && i_cfg[0])),
        .i_waddr(w_clr ? r_clr[7:0] : r_it.base),
        .i_wdata(w_clr ? 64'd0 : ((&w_bh) ? w_bh : w_bh + 64'd1)),
        .i_raddr(r_st == S_IDLE ? i_item.index[7:0] : r_it.base), .o_rdata(w_bh));
    ssa_ram #(.WIDTH(64), .DEPTH(256)) u_qh (
        .i_clk(i_clk),
        .i_we(w_clr || (r_st == S_WR && r_it.op == OP_SYMBOL && i_cfg[1] && r_it.has_q)),
        .i_waddr(w_clr ? r_clr[7:0] : r_it.qual),
        .i_wdata(w_clr ? 64'd0 : ((&w_qh) ? w_qh : w_qh + 64'd1)),
        .i_raddr(r_st == S_IDLE ? i_item.index[7:0] : r_it.qual), .o_rdata(w_qh));
    ssa_ram #(.WIDTH(32), .DEPTH(LEN_BINS)) u_bc (
        .i_clk(i_clk), .i_we(w_clr || (r_st == S_WR && r_it.op == OP_END)),
        .i_waddr(w_clr ? r_clr[BW-1:0] : r_bin),
        .i_wdata(w_clr ? 32'd0 : ((&w_bc) ? w_bc : w_bc + 32'd1)),
        .i_raddr(w_baddr), .o_rdata(w_bc));
    logic [64:0] w_sum;
    assign w_sum = {1'b0, w_bs} + {33'd0, r_len};
    ssa_ram #(.WIDTH(64), .DEPTH(LEN_BINS)) u_bs (
        .i_clk(i_clk), .i_we(w_clr || (r_st == S_WR && r_it.op == OP_END)),
        .i_waddr(w_clr ? r_clr[BW-1:0] : r_bin),
        .i_wdata(w_clr ? 64'd0 : (w_sum[64] ? {64{1'b1}} : w_sum[63:0])),
        .i_raddr(w_baddr), .o_rdata(w_bs));

    assign o_take      = (r_st == S_IDLE) && i_valid && !(i_item.op == OP_READ && r_resv);
    assign o_res_valid = r_resv;
    assign o_res       = r_res;
    assign w_rb        = r_root + r_bit;

    logic [64:0] w_tot;
    assign w_tot = {1'b0, r_total} + {33'd0, r_cur};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_resv <= 1'b0;
            r_cur <= '0; r_min <= '0; r_max <= '0; r_total <= '0; r_seqs <= '0;
        end else begin
            if (r_resv && i_res_take) r_resv <= 1'b0;
            unique case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) r_st <= S_IDLE;
                end
                S_IDLE: if (o_take) begin
                    r_it <= i_item;
                    if (i_item.op == OP_READ) begin
                        r_st <= S_OUT;
                    end else if (i_item.op == OP_SYMBOL) begin
                        r_st <= S_RD;
                        if (!(&r_cur)) r_cur <= r_cur + 32'd1;
                    end else begin
                        r_len   <= r_cur;
                        r_cur   <= '0;
                        r_seqs  <= (&r_seqs) ? r_seqs : r_seqs + 64'd1;
                        r_total <= w_tot[64] ? {64{1'b1}} : w_tot[63:0];
                        if (r_cur > r_max) r_max <= r_cur;
                        if (r_min == 32'd0 || r_cur < r_min) r_min <= r_cur;
                        r_v      <= {10'd0, r_cur} * 42'd100;
                        r_root   <= '0;
                        r_bit    <= 42'd1 << 40;
                        r_bin_on <= i_cfg[2];
                        r_st     <= i_cfg[2] ? S_SQRT : S_IDLE;
                    end
                end
                S_SQRT: begin
                    if (r_bit == 42'd0) begin
                        r_bin <= (r_root > 42'(LEN_BINS - 1)) ? BW'(LEN_BINS - 1)
                                                               : r_root[BW-1:0];
                        r_st  <= S_RD;
                    end else begin
                        if (r_v >= w_rb) begin
                            r_v    <= r_v - w_rb;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_RD: r_st <= S_WR;
                S_WR: r_st <= S_IDLE;
                S_OUT: begin
                    r_resv <= 1'b1;
                    r_st   <= S_IDLE;
                    r_res  <= '0;
                    case (r_it.table_sel)
                        TBL_BASE: if (r_it.index < 12'd256) r_res <= w_bh;
                        TBL_QUAL: if (r_it.index < 12'd256) r_res <= w_qh;
                        TBL_BCOUNT: if (32'(r_it.index) < LEN_BINS) r_res <= {32'd0, w_bc};
                        TBL_BSUM: if (32'(r_it.index) < LEN_BINS) r_res <= w_bs;
                        TBL_SCALAR: begin
                            case (r_it.index)
                                SC_COUNT: r_res <= r_seqs;
                                SC_TOTAL: r_res <= r_total;
                                SC_MIN:   r_res <= {32'd0, r_min};
                                SC_MAX:   r_res <= {32'd0, r_max};
                                default:  r_res <= '0;
                            endcase
                        end
                        default: r_res <= '0;
                    endcase
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_sqrt_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_SQRT |-> r_it.op == OP_END) else $error("sqrt on non-end item");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> r_st == S_IDLE) else $error("take while busy");
    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_OUT |-> !r_resv) else $error("result overwritten");
    a_bin_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_SQRT |-> r_bin_on) else $error("binning while disabled");
endmodule

[src/sequence_stats_accumulator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_stats_accumulator_unit
// Accumulates base and quality histograms and sequence length statistics.
// Input items enter through a queue interface: an item is taken when push
// is high and full is low. Read results leave through a queue interface:
// empty low shows a result, taken when pop is high.
// Configuration bits are written through i_cfg_we, i_cfg_index, i_cfg_data.
// A symbol item passes the read and write states, a read item the output
// state. An end item returns to idle, or with length binning runs the
// square root iteration, then the read and write states. A two-entry queue
// parts the input stage from the execution engine. After reset a clearing
// pass over LEN_BINS addresses, at least 256, zeroes the memories; items
// wait in the queue meanwhile. A stalled result blocks only further reads.
// ----------------------------------------------------------------------------
module sequence_stats_accumulator_unit
    import ssa_pkg::*;
#(
    parameter int LEN_BINS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_base_symbol,
    input  logic [7:0]  i_quality_symbol,
    input  logic        i_has_quality,
    input  logic [2:0]  i_read_table,
    input  logic [11:0] i_read_index,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_read_value,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data
);
    logic [2:0] r_cfg;
    t_item      w_in, w_it;
    logic       w_v, w_take, w_rv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COUNT_BASES:     r_cfg[0] <= i_cfg_data;
                CFG_COUNT_QUALITIES: r_cfg[1] <= i_cfg_data;
                CFG_BIN_LENGTHS:     r_cfg[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_in = '{op: i_operation, base: i_base_symbol, qual: i_quality_symbol,
                    has_q: i_has_quality, table_sel: i_read_table, index: i_read_index};

    ssa_front u_front (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(w_in), .o_valid(w_v), .o_item(w_it), .i_take(w_take));

    ssa_back #(.LEN_BINS(LEN_BINS)) u_back (.i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg(r_cfg), .i_valid(w_v), .i_item(w_it), .o_take(w_take),
        .o_res_valid(w_rv), .o_res(o_read_value), .i_res_take(pop));

    assign empty = !w_rv;
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives symbol, end-of-sequence and read beats into the sequence statistics
// accumulator under several register settings and idling mixes, predicts
// every counter in a shadow copy of its state and compares each read beat.
// ----------------------------------------------------------------------------
module tb_top;
    import ssa_pkg::*;

    localparam int NBINS = 4096;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        t_item       it;
        logic        chk;
        logic [63:0] exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_operation;
    logic [7:0]  i_base_symbol;
    logic [7:0]  i_quality_symbol;
    logic        i_has_quality;
    logic [2:0]  i_read_table;
    logic [11:0] i_read_index;
    logic        empty;
    logic        pop;
    logic [63:0] o_read_value;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic        i_cfg_data;

    sequence_stats_accumulator_unit #(.LEN_BINS(NBINS)) dut (.*);

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [63:0] base_hist [256];
    logic [63:0] qual_hist [256];
    logic [31:0] bin_count [NBINS];
    logic [63:0] bin_sum [NBINS];
    logic [31:0] cur_len;
    logic [63:0] total_len;
    logic [31:0] min_len;
    logic [31:0] max_len;
    logic [63:0] seq_count;
    logic        en_bases, en_quals, en_bins;

    logic [63:0] pending_reads [$];
    int          mismatches = 0;
    int          cycles = 0;
    int          send_idle = 0;
    int          recv_stall = 0;
    int          hold_off = 0;

    function automatic logic [63:0] add_sat64(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [31:0] len_bin(logic [31:0] len);
        longint unsigned v;
        longint unsigned r;
        v = 64'(len) * 100;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= v) begin
                r = r + (64'd1 << b);
            end
        end
        return (r > NBINS - 1) ? 32'(NBINS - 1) : r[31:0];
    endfunction

    function automatic void tally_item(t_item it);
        logic [31:0] b;
        case (it.op)
            OP_SYMBOL: begin
                if (en_bases) base_hist[it.base] = add_sat64(base_hist[it.base], 1);
                if (en_quals && it.has_q) begin
                    qual_hist[it.qual] = add_sat64(qual_hist[it.qual], 1);
                end
                if (cur_len != '1) cur_len = cur_len + 1;
            end
            OP_END: begin
                seq_count = add_sat64(seq_count, 1);
                total_len = add_sat64(total_len, 64'(cur_len));
                if (cur_len > max_len) max_len = cur_len;
                if (min_len == 0 || cur_len < min_len) min_len = cur_len;
                if (en_bins) begin
                    b = len_bin(cur_len);
                    if (bin_count[b] != '1) bin_count[b] = bin_count[b] + 1;
                    bin_sum[b] = add_sat64(bin_sum[b], 64'(cur_len));
                end
                cur_len = 0;
            end
            OP_READ: begin
                logic [63:0] v;
                v = 0;
                case (it.table_sel)
                    TBL_BASE:   if (it.index < 256) v = base_hist[it.index[7:0]];
                    TBL_QUAL:   if (it.index < 256) v = qual_hist[it.index[7:0]];
                    TBL_BCOUNT: v = 64'(bin_count[it.index]);
                    TBL_BSUM:   v = bin_sum[it.index];
                    TBL_SCALAR: begin
                        case (it.index)
                            SC_COUNT: v = seq_count;
                            SC_TOTAL: v = total_len;
                            SC_MIN:   v = 64'(min_len);
                            SC_MAX:   v = 64'(max_len);
                            default:  v = 0;
                        endcase
                    end
                    default: v = 0;
                endcase
                pending_reads.push_back(v);
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (i_rst_n && pop && !empty) begin
            if (pending_reads.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected read beat %h", o_read_value);
            end else begin
                if (o_read_value !== pending_reads[0]) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("read_value mismatch: expected %h got %h",
                                 pending_reads[0], o_read_value);
                    end
                end
                void'(pending_reads.pop_front());
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_beat(t_item it);
        if ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < send_idle) @(negedge i_clk);
        end
        push <= 1'b1;
        i_operation <= it.op;
        i_base_symbol <= it.base;
        i_quality_symbol <= it.qual;
        i_has_quality <= it.has_q;
        i_read_table <= it.table_sel;
        i_read_index <= it.index;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        tally_item(it);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_reads.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_COUNT_BASES:     en_bases = val;
            CFG_COUNT_QUALITIES: en_quals = val;
            CFG_BIN_LENGTHS:     en_bins = val;
            default: ;
        endcase
    endtask

    function automatic t_item make_item(logic [1:0] op, logic [7:0] b, logic [7:0] q,
                                        logic hq, logic [2:0] tbl, logic [11:0] ix);
        t_item it;
        it.op = op; it.base = b; it.qual = q; it.has_q = hq;
        it.table_sel = tbl; it.index = ix;
        return it;
    endfunction

    function automatic t_row make_row(t_item it, logic chk, logic [63:0] exp);
        t_row row;
        row.it = it; row.chk = chk; row.exp = exp;
        return row;
    endfunction

    function automatic t_item random_item();
        t_item it;
        logic [63:0] rnd;
        int r;
        rnd = {$urandom, $urandom};
        it = rnd[$bits(t_item)-1:0];
        r = $urandom_range(99);
        if (r < 70) begin
            it.op = OP_SYMBOL;
        end else if (r < 80) begin
            it.op = OP_END;
        end else if (r < 97) begin
            it.op = OP_READ;
            if ($urandom_range(3) != 0) begin
                it.table_sel = 3'($urandom_range(4));
                if (it.table_sel == TBL_SCALAR) begin
                    it.index = 12'($urandom_range(4));
                end else if (it.table_sel >= TBL_BCOUNT) begin
                    it.index = 12'($urandom_range(80));
                end else begin
                    it.index = {4'd0, it.index[7:0]};
                end
            end
        end else begin
            it.op = OP_NOP;
        end
        return it;
    endfunction

    t_row directed [$];

    initial begin
        push = 1'b0; pop = 1'b0; i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = 1'b0;
        i_operation = '0; i_base_symbol = '0; i_quality_symbol = '0; i_has_quality = 1'b0;
        i_read_table = '0; i_read_index = '0;
        i_rst_n = 1'b0;
        foreach (base_hist[k]) begin base_hist[k] = 0; qual_hist[k] = 0; end
        foreach (bin_count[k]) begin bin_count[k] = 0; bin_sum[k] = 0; end
        cur_len = 0; total_len = 0; min_len = 0; max_len = 0; seq_count = 0;
        en_bases = 0; en_quals = 0; en_bins = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Count and minimum read zero after reset; out-of-range reads give zero too.
        directed = '{
            make_row(make_item(OP_READ, 0, 0, 0, TBL_SCALAR, SC_COUNT), 1, 0),
            make_row(make_item(OP_READ, 0, 0, 0, TBL_SCALAR, SC_MIN), 1, 0),
            make_row(make_item(OP_END, 0, 0, 0, 0, 0), 0, 0),
            make_row(make_item(OP_SYMBOL, 8'hFF, 8'hFF, 1, 0, 0), 0, 0),
            make_row(make_item(OP_SYMBOL, 8'h00, 8'h00, 1, 0, 0), 0, 0),
            make_row(make_item(OP_SYMBOL, 8'hAA, 8'h55, 0, 0, 0), 0, 0),
            make_row(make_item(OP_END, 0, 0, 0, 0, 0), 0, 0),
            make_row(make_item(OP_NOP, 0, 0, 0, 0, 0), 0, 0),
            make_row(make_item(OP_READ, 0, 0, 0, TBL_BASE, 12'hFF), 1, 1),
            make_row(make_item(OP_READ, 0, 0, 0, TBL_QUAL, 12'h0), 1, 1),
            make_row(make_item(OP_READ, 0, 0, 0, TBL_BASE, 12'h100), 1, 0),
            make_row(make_item(OP_READ, 0, 0, 0, TBL_BCOUNT, 12'd0), 0, 0),
            make_row(make_item(OP_READ, 0, 0, 0, TBL_BCOUNT, 12'd17), 0, 0),
            make_row(make_item(OP_READ, 0, 0, 0, TBL_BSUM, 12'hFFF), 1, 0),
            make_row(make_item(OP_READ, 0, 0, 0, TBL_SCALAR, SC_TOTAL), 1, 3),
            make_row(make_item(OP_READ, 0, 0, 0, TBL_SCALAR, SC_MAX), 1, 3),
            make_row(make_item(OP_READ, 0, 0, 0, TBL_SCALAR, 12'hFFF), 1, 0),
            make_row(make_item(OP_READ, 0, 0, 0, 3'd7, 12'd0), 1, 0),
            make_row(make_item(OP_READ, 0, 0, 0, 3'd5, 12'd1), 1, 0)
        };

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 86; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 86; end
                3: begin send_idle = 32; recv_stall = 32; end
                4: begin send_idle = 0;  recv_stall = 0;  end
                default: begin send_idle = 32; recv_stall = 0; end
            endcase
            write_reg(CFG_COUNT_BASES, phase == 0 || phase[0]);
            write_reg(CFG_COUNT_QUALITIES, phase == 0 || phase == 2 || phase == 3);
            write_reg(CFG_BIN_LENGTHS, phase != 1 && phase != 4);
            if (phase == 0) begin
                foreach (directed[k]) begin
                    send_beat(directed[k].it);
                    if (directed[k].chk) begin
                        pending_reads[pending_reads.size() - 1] = directed[k].exp;
                    end
                end
            end
            if (phase == 4) hold_off = 300;
            repeat (120) send_beat(random_item());
            // Close the open sequence so no length carries across a register change.
            send_beat(make_item(OP_END, 0, 0, 0, 0, 0));
            drain_results();
        end
        // A longer sequence for bins beyond the first few dozen.
        repeat (900) send_beat(make_item(OP_SYMBOL, 8'($urandom), 8'($urandom), 1, 0, 0));
        send_beat(make_item(OP_END, 0, 0, 0, 0, 0));
        send_beat(make_item(OP_READ, 0, 0, 0, TBL_BCOUNT, 12'(len_bin(32'd900))));
        send_beat(make_item(OP_READ, 0, 0, 0, TBL_SCALAR, SC_MAX));
        drain_results();

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
